// ----- sv/sha256_pkg.sv -----
// Package: SHA-256 constants, round functions and shared types.
package sha256_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 64;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [63:0] BLOCK_BITS = 64'd512;

    localparam logic [0:0] CMD_ABSORB = 1'b0;
    localparam logic [0:0] CMD_FINISH = 1'b1;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] hash_t;

    localparam hash_t INIT_HASH = '{
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // control between top level and compression engine
    typedef struct packed {
        logic start;
    } eng_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_sts_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        begin
            unique case (i)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
                6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
                6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
                6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
                6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
                6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
                6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
                6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
                6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
                6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
                6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
                default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic word_t ror32(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- sv/sha256_engine.sv -----
// SHA-256 compression engine: one round per cycle, schedule in a 16-word window.
module sha256_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha256_pkg::eng_ctl_t  ctl,
    input  sha256_pkg::word_t     w_in,      // message word for round 0..15
    output logic [3:0]            w_addr,    // which message word is wanted next
    input  sha256_pkg::hash_t     chain_in,
    output sha256_pkg::hash_t     chain_out,
    output sha256_pkg::eng_sts_t  sts
);
    // w_in is the registered read of word w_addr issued the cycle before.
    logic              busy_reg, busy_next;
    logic              done_reg;
    logic [5:0]        rnd_reg, rnd_next;
    sha256_pkg::hash_t v_reg, v_next;
    sha256_pkg::word_t win_reg [16];
    sha256_pkg::word_t w_cur, s0, s1, t1, t2, big0, big1, ch, maj, w15, w2;

    assign w_addr = busy_reg ? rnd_reg[3:0] + 4'd1 : 4'd0;

    always_comb begin
        w15 = win_reg[1];
        w2  = win_reg[14];
        s0  = sha256_pkg::ror32(w15, 7) ^ sha256_pkg::ror32(w15, 18) ^ (w15 >> 3);
        s1  = sha256_pkg::ror32(w2, 17) ^ sha256_pkg::ror32(w2, 19) ^ (w2 >> 10);
        w_cur = (rnd_reg < 6'd16) ? w_in : s1 + win_reg[9] + s0 + win_reg[0];
        big1 = sha256_pkg::ror32(v_reg[4], 6) ^ sha256_pkg::ror32(v_reg[4], 11)
             ^ sha256_pkg::ror32(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + sha256_pkg::round_k(rnd_reg) + w_cur;
        big0 = sha256_pkg::ror32(v_reg[0], 2) ^ sha256_pkg::ror32(v_reg[0], 13)
             ^ sha256_pkg::ror32(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
        v_next    = v_reg;
        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        if (ctl.start && !busy_reg) begin
            v_next    = chain_in;
            busy_next = 1'b1;
            rnd_next  = 6'd0;
        end else if (busy_reg) begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
            rnd_next  = rnd_reg + 6'd1;
            if (rnd_reg == 6'd63) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
        if (busy_reg) begin
            for (int i = 0; i < 15; i++) win_reg[i] <= win_reg[i+1];
            win_reg[15] <= w_cur;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            done_reg <= busy_reg && (rnd_reg == 6'd63);
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) chain_out[i] = chain_in[i] + v_reg[i];
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// ----- sv/sha256_byte_stream_hasher_core.sv -----
// Top level: byte-stream SHA-256 hasher with block memory, padding and digest output.
//
//  channel | dir | handshake        | payload
//  s_      | in  | tvalid/tready    | tdata[0]=command, tdata[8:1]=data_byte
//  m_      | out | tvalid/tready    | tdata=digest_word, tuser=word_index, tlast=last
//
// An absorb request is taken while idle; the 64th byte of a block also starts a
// compression (64 rounds in the engine plus the chain update), during which
// no byte is taken. Finish writes padding one byte per cycle into the block
// memory, runs one or two compressions, then offers eight digest words.
// The 64-byte block lives in a 16x32 memory with a registered read feeding the
// engine. Reset is synchronous; block memory needs no clearing.
// m_tready low holds the current digest word; s_tready is low while busy.
module sha256_byte_stream_hasher_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] command, [8:1] data_byte, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;   // zero fill after 0x80
    localparam logic [2:0] ST_LEN  = 3'd2;   // writing length bytes
    localparam logic [2:0] ST_COMP = 3'd3;   // compression running
    localparam logic [2:0] ST_OUT  = 3'd4;   // digest out

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] blen_reg, blen_next;
    logic [63:0] total_reg, total_next;
    logic        fin_reg, fin_next;        // finishing: padding, final compression and digest output in progress
    logic        lenblk_reg, lenblk_next;  // current compression carries the length
    logic [2:0]  oidx_reg, oidx_next;
    sha256_pkg::hash_t chain_reg, chain_next;

    // block memory, 16 words, byte writes
    logic [31:0] mem [16];
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data_reg;

    sha256_pkg::eng_ctl_t ctl;
    sha256_pkg::eng_sts_t sts;
    sha256_pkg::hash_t    chain_sum;
    logic [3:0]           eng_addr;

    logic       acc;
    logic       cmd;
    logic [7:0] dbyte;

    assign cmd   = s_tdata[0];
    assign dbyte = s_tdata[8:1];
    assign s_tready = (state_reg == ST_IDLE);
    assign acc   = s_tvalid && s_tready;
    assign rd_addr = eng_addr;

    // byte 0 of a word is its most significant byte
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    sha256_engine u_eng (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .w_in      (rd_data_reg),
        .w_addr    (eng_addr),
        .chain_in  (chain_reg),
        .chain_out (chain_sum),
        .sts       (sts)
    );

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        blen_next   = blen_reg;
        total_next  = total_reg;
        fin_next    = fin_reg;
        lenblk_next = lenblk_reg;
        oidx_next   = oidx_reg;
        chain_next  = chain_reg;
        wr_en       = 1'b0;
        wr_addr     = fill_reg;
        wr_data     = dbyte;
        ctl.start   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    wr_en = 1'b1;
                    if (cmd == sha256_pkg::CMD_ABSORB) begin
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63) begin
                            ctl.start   = 1'b1;
                            lenblk_next = 1'b0;
                            blen_next   = blen_reg + sha256_pkg::BLOCK_BITS;
                            state_next  = ST_COMP;
                        end
                    end else begin
                        wr_data    = sha256_pkg::PAD_BYTE;
                        total_next = blen_reg + {55'd0, fill_reg, 3'd0};
                        fin_next   = 1'b1;
                        fill_next  = fill_reg + 6'd1;
                        state_next = (fill_reg < 6'd55) ? ST_PAD
                                   : (fill_reg == 6'd55) ? ST_LEN : ST_PAD;
                        if (fill_reg == 6'd63) begin
                            ctl.start   = 1'b1;
                            lenblk_next = 1'b0;
                            state_next  = ST_COMP;
                        end
                    end
                end
            end
            ST_PAD: begin
                wr_en     = 1'b1;
                wr_data   = 8'd0;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd55) state_next = ST_LEN;
                if (fill_reg == 6'd63) begin
                    ctl.start   = 1'b1;
                    lenblk_next = 1'b0;
                    state_next  = ST_COMP;
                end
            end
            ST_LEN: begin
                // byte 56 carries the top length byte
                wr_en     = 1'b1;
                wr_data   = total_reg[{~fill_reg[2:0], 3'b000} +: 8];
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63) begin
                    ctl.start   = 1'b1;
                    lenblk_next = 1'b1;
                    state_next  = ST_COMP;
                end
            end
            ST_COMP: begin
                if (sts.done) begin
                    chain_next = chain_sum;
                    if (!fin_reg) state_next = ST_IDLE;
                    else if (lenblk_reg) begin
                        state_next = ST_OUT;
                        oidx_next  = 3'd0;
                    end else state_next = ST_PAD;  // second padded block from byte 0
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7) begin
                        state_next = ST_IDLE;
                        chain_next = sha256_pkg::INIT_HASH;
                        fill_next  = '0;
                        blen_next  = '0;
                        fin_next   = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            blen_reg   <= '0;
            fin_reg    <= 1'b0;
            lenblk_reg <= 1'b0;
            oidx_reg   <= '0;
            chain_reg  <= sha256_pkg::INIT_HASH;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            blen_reg   <= blen_next;
            fin_reg    <= fin_next;
            lenblk_reg <= lenblk_next;
            oidx_reg   <= oidx_next;
            chain_reg  <= chain_next;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain_reg[oidx_reg];
    assign m_tuser  = oidx_reg;
    assign m_tlast  = (oidx_reg == 3'd7);

endmodule
